// ===== sv/bis_pkg.sv =====
// shared types and constants for the bilinear image scaler
package bis_pkg;

    localparam int FRAC_BITS     = 18;
    localparam int POS_W         = 37;
    localparam int IPART_W       = POS_W - FRAC_BITS;
    localparam int SIZE_W        = 9;
    localparam int COORD_W       = 8;
    localparam int WGT_W         = 9;
    localparam int PROD_W        = 17;
    localparam int STEP_W        = 24;
    localparam int OFS_W         = 25;
    localparam int DST_W         = 10;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 25;
    localparam int TDATA_W       = 48;

    localparam logic [SIZE_W-1:0] MAX_SRC_WIDTH  = 9'd256;
    localparam logic [SIZE_W-1:0] MAX_SRC_HEIGHT = 9'd256;
    localparam logic [WGT_W-1:0]  ONE_WEIGHT     = 9'h100;
    localparam logic [POS_W-1:0]  ROUND_HALF     = 37'h8000;
    localparam logic [FRAC_BITS:0] FRAC_ROUND    = 19'h200;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET   = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MX,
        S_MY,
        S_SY,
        S_WT,
        S_AC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [COORD_W-1:0] c0;
        logic [COORD_W-1:0] c1;
        logic [WGT_W-1:0]   f;
    } t_split;

endpackage

// ===== sv/bis_mac.sv =====
// shared multiply-add unit: a * b + c
module bis_mac (
    input  logic [bis_pkg::STEP_W-1:0]       i_a,
    input  logic [bis_pkg::DST_W-1:0]        i_b,
    input  logic signed [bis_pkg::POS_W-1:0] i_c,
    output logic signed [bis_pkg::POS_W-1:0] o_res
);
    import bis_pkg::*;

    logic [STEP_W+DST_W-1:0] prod;

    assign prod  = i_a * i_b;
    assign o_res = i_c + signed'({{(POS_W-STEP_W-DST_W){1'b0}}, prod});

endmodule

// ===== sv/bis_split.sv =====
// splits a fixed-point position into clamped neighbor coordinates and a weight
module bis_split (
    input  logic signed [bis_pkg::POS_W-1:0] i_pos,
    input  logic [bis_pkg::SIZE_W-1:0]       i_size,
    input  logic                             i_is_y,
    output bis_pkg::t_split                  o_split
);
    import bis_pkg::*;

    logic [SIZE_W-1:0]    size_max;
    logic [SIZE_W-1:0]    size_eff;
    logic [COORD_W-1:0]   last;
    logic [IPART_W-1:0]   ipart;
    logic [FRAC_BITS:0]   frac_sum;
    logic                 neg;
    logic                 ge;
    logic [COORD_W-1:0]   c0;

    always_comb begin
        size_max = i_is_y ? MAX_SRC_HEIGHT : MAX_SRC_WIDTH;
        if (i_size == '0) begin
            size_eff = SIZE_W'(1);
        end else if (i_size > size_max) begin
            size_eff = size_max;
        end else begin
            size_eff = i_size;
        end
        last     = COORD_W'(size_eff - SIZE_W'(1));
        ipart    = i_pos[POS_W-1:FRAC_BITS];
        neg      = i_pos[POS_W-1];
        ge       = ipart >= IPART_W'(last);
        frac_sum = {1'b0, i_pos[FRAC_BITS-1:0]} + FRAC_ROUND;
        if (neg) begin
            c0 = '0;
        end else if (ge) begin
            c0 = last;
        end else begin
            c0 = ipart[COORD_W-1:0];
        end
        o_split.c0 = c0;
        o_split.f  = frac_sum[FRAC_BITS:FRAC_BITS-8];
        if (i_is_y) begin
            // top and bottom edges duplicate the clamped row
            o_split.c1 = (neg || ge) ? c0 : c0 + COORD_W'(1);
        end else begin
            o_split.c1 = (c0 < last) ? c0 + COORD_W'(1) : last;
        end
    end

endmodule

// ===== sv/bilinear_image_scaler.sv =====
// bilinear image scaler top level: source store, sequencer and datapath
// load transaction: written in the cycle it is accepted, one load per cycle while idle
// query transaction: S_MX, S_MY, S_SY, four S_WT/S_AC, then S_DONE loads the result
// one query at a time until its result loads: one multiply-add unit does both positions,
//   four weights and four accumulations; the single-port store gives one neighbor per read
// reset: synchronous active low, config back to defaults, source store not cleared
module bilinear_image_scaler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [bis_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bis_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // src_col[7:0], src_row[15:8], src_value[23:16], dst_col[33:24], dst_row[43:34]
    input  logic [bis_pkg::TDATA_W-1:0]       s_axis_tdata,
    // command[0]
    input  logic                              s_axis_tuser,
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_pixel[7:0]
    output logic [7:0]                        m_axis_tdata
);
    import bis_pkg::*;

    // configuration registers
    logic [SIZE_W-1:0]        r_src_width;
    logic [SIZE_W-1:0]        r_src_height;
    logic [STEP_W-1:0]        r_x_step;
    logic [STEP_W-1:0]        r_y_step;
    logic signed [OFS_W-1:0]  r_x_offset;
    logic signed [OFS_W-1:0]  r_y_offset;

    // sequencer state
    t_state                   r_state;
    t_state                   n_state;
    logic [1:0]               r_k;

    // query datapath registers
    logic [DST_W-1:0]         r_dst_col;
    logic [DST_W-1:0]         r_dst_row;
    logic signed [POS_W-1:0]  r_acc;
    logic [PROD_W-1:0]        r_w;
    logic [7:0]               r_rd;
    logic [COORD_W-1:0]       r_x0;
    logic [COORD_W-1:0]       r_x1;
    logic [WGT_W-1:0]         r_xf;
    logic [COORD_W-1:0]       r_y0;
    logic [COORD_W-1:0]       r_y1;
    logic [WGT_W-1:0]         r_yf;

    // output register
    logic                     r_out_valid;
    logic [7:0]               r_out_data;

    // source store, 256 x 256, addressed {row, col}
    logic [7:0]               r_mem [2**(2*COORD_W)];

    logic                     in_accept;
    logic                     load_we;
    logic                     out_load;
    logic [STEP_W-1:0]        mac_a;
    logic [DST_W-1:0]         mac_b;
    logic signed [POS_W-1:0]  mac_c;
    logic signed [POS_W-1:0]  mac_res;
    logic [SIZE_W-1:0]        split_size;
    logic                     split_is_y;
    t_split                   split_out;
    logic [WGT_W-1:0]         wx;
    logic [WGT_W-1:0]         wy;
    logic [2*COORD_W-1:0]     rd_addr;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign load_we   = in_accept && (s_axis_tuser == CMD_LOAD);

    // neighbor k: bit 0 picks the right column, bit 1 the lower row
    assign wx      = r_k[0] ? r_xf : ONE_WEIGHT - r_xf;
    assign wy      = r_k[1] ? r_yf : ONE_WEIGHT - r_yf;
    assign rd_addr = {(r_k[1] ? r_y1 : r_y0), (r_k[0] ? r_x1 : r_x0)};

    bis_mac u_mac (
        .i_a   (mac_a),
        .i_b   (mac_b),
        .i_c   (mac_c),
        .o_res (mac_res)
    );

    bis_split u_split (
        .i_pos   (r_acc),
        .i_size  (split_size),
        .i_is_y  (split_is_y),
        .o_split (split_out)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept && (s_axis_tuser == CMD_QUERY)) begin
                    n_state = S_MX;
                end
            end
            S_MX:   n_state = S_MY;
            S_MY:   n_state = S_SY;
            S_SY:   n_state = S_WT;
            S_WT:   n_state = S_AC;
            S_AC: begin
                n_state = (r_k == 2'd3) ? S_DONE : S_WT;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: handshake and shared unit operand select
    always_comb begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        mac_a         = '0;
        mac_b         = '0;
        mac_c         = '0;
        split_size    = r_src_height;
        split_is_y    = 1'b1;
        case (r_state)
            // not ready while reset is held
            S_IDLE: s_axis_tready = i_rst_n;
            S_MX: begin
                mac_a = r_x_step;
                mac_b = r_dst_col;
                mac_c = POS_W'(r_x_offset);
            end
            S_MY: begin
                // x position sits in r_acc while y is computed
                mac_a      = r_y_step;
                mac_b      = r_dst_row;
                mac_c      = POS_W'(r_y_offset);
                split_size = r_src_width;
                split_is_y = 1'b0;
            end
            S_WT: begin
                mac_a = STEP_W'(wx);
                mac_b = DST_W'(wy);
            end
            S_AC: begin
                mac_a = STEP_W'(r_w);
                mac_b = DST_W'(r_rd);
                mac_c = r_acc;
            end
            S_DONE: out_load = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_k          <= '0;
            r_out_valid  <= 1'b0;
            r_src_width  <= MAX_SRC_WIDTH;
            r_src_height <= MAX_SRC_HEIGHT;
            r_x_step     <= STEP_W'(1 << FRAC_BITS);
            r_y_step     <= STEP_W'(1 << FRAC_BITS);
            r_x_offset   <= '0;
            r_y_offset   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_AC) begin
                r_k <= r_k + 2'd1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SRC_WIDTH:  r_src_width  <= i_cfg_data[SIZE_W-1:0];
                    REG_SRC_HEIGHT: r_src_height <= i_cfg_data[SIZE_W-1:0];
                    REG_X_STEP:     r_x_step     <= i_cfg_data[STEP_W-1:0];
                    REG_Y_STEP:     r_y_step     <= i_cfg_data[STEP_W-1:0];
                    REG_X_OFFSET:   r_x_offset   <= signed'(i_cfg_data[OFS_W-1:0]);
                    REG_Y_OFFSET:   r_y_offset   <= signed'(i_cfg_data[OFS_W-1:0]);
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_dst_col <= s_axis_tdata[33:24];
            r_dst_row <= s_axis_tdata[43:34];
        end
        case (r_state)
            S_MX: r_acc <= mac_res;
            S_MY: begin
                r_acc <= mac_res;
                r_x0  <= split_out.c0;
                r_x1  <= split_out.c1;
                r_xf  <= split_out.f;
            end
            S_SY: begin
                r_y0  <= split_out.c0;
                r_y1  <= split_out.c1;
                r_yf  <= split_out.f;
                r_acc <= signed'(ROUND_HALF);
            end
            S_WT: r_w <= mac_res[PROD_W-1:0];
            S_AC: r_acc <= mac_res;
            default: ;
        endcase
        if (out_load) begin
            r_out_data <= r_acc[23:16];
        end
    end

    // source store: one write or one read per cycle
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            r_mem[{s_axis_tdata[15:8], s_axis_tdata[7:0]}] <= s_axis_tdata[23:16];
        end else if (r_state == S_WT) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // a query transaction always starts the position step
    a_query_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (s_axis_tuser == CMD_QUERY)) |=> (r_state == S_MX))
        else $error("query did not start position step");

    // each weight product stays within 256 * 256
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AC) |-> (r_w <= PROD_W'(65536)))
        else $error("weight product out of range");

    // the rounded weighted sum fits in 24 bits
    a_sum_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_acc[POS_W-1:24] == '0))
        else $error("weighted sum overflow");

    // four neighbors are visited before the result is taken
    a_four_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_AC) && (r_k == 2'd3)) |=> ((r_state == S_DONE) && (r_k == 2'd0)))
        else $error("neighbor count mismatch");

    // the output register only loads from the done state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside done state");

endmodule

// ===== sim/bis_pixel_checker.sv =====
// checker for the bilinear image scaler: tracks config and source image, predicts each pixel
module bis_pixel_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bis_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bis_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // src_col[7:0], src_row[15:8], src_value[23:16], dst_col[33:24], dst_row[43:34]
    input  logic [bis_pkg::TDATA_W-1:0]    i_s_tdata,
    // command[0]
    input  logic                           i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // out_pixel[7:0]
    input  logic [7:0]                     i_m_tdata,
    output int                             o_fail_count,
    output int                             o_pending
);
    import bis_pkg::*;

    localparam int unsigned ROW_PITCH = MAX_SRC_WIDTH;
    localparam int unsigned FULL_WGT  = ONE_WEIGHT;
    localparam int unsigned SUM_ROUND = 32'h8000;

    logic [7:0]              src_img [0:65535];
    logic [SIZE_W-1:0]       width_reg;
    logic [SIZE_W-1:0]       height_reg;
    logic [STEP_W-1:0]       xstep_reg;
    logic [STEP_W-1:0]       ystep_reg;
    logic signed [OFS_W-1:0] xofs_reg;
    logic signed [OFS_W-1:0] yofs_reg;
    logic [7:0]              expected_pixels [$];
    int                      mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    // 0 behaves as 1, anything above the store size as the store size
    function automatic int unsigned active_dim(logic [SIZE_W-1:0] v, logic [SIZE_W-1:0] lim);
        if (v == '0) return 1;
        if (v > lim) return int'(lim);
        return int'(v);
    endfunction

    // fraction rounded to 8 bits, may reach a full 256
    function automatic int unsigned fraction_weight(longint p);
        longint fr;
        fr = p & ((longint'(1) << FRAC_BITS) - 1);
        return int'((fr + (longint'(1) << (FRAC_BITS - 9))) >> (FRAC_BITS - 8));
    endfunction

    function automatic logic [7:0] interp_pixel(logic [DST_W-1:0] dc, logic [DST_W-1:0] dr);
        int unsigned w, h, x0, x1, y0, y1, wx, wy, sum;
        longint      px, py, xi, yi;
        w  = active_dim(width_reg, MAX_SRC_WIDTH);
        h  = active_dim(height_reg, MAX_SRC_HEIGHT);
        px = longint'(xofs_reg) + longint'(dc) * longint'(xstep_reg);
        py = longint'(yofs_reg) + longint'(dr) * longint'(ystep_reg);
        xi = px >>> FRAC_BITS;
        yi = py >>> FRAC_BITS;
        wx = fraction_weight(px);
        wy = fraction_weight(py);
        // horizontal: clamp left column, right neighbor stays inside the image
        if (xi < 0)
            x0 = 0;
        else if (xi >= longint'(w - 1))
            x0 = w - 1;
        else
            x0 = int'(xi);
        x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
        // vertical: past either edge, both rows collapse onto the edge row
        if (yi < 0) begin
            y0 = 0;
            y1 = 0;
        end else if (yi >= longint'(h - 1)) begin
            y0 = h - 1;
            y1 = h - 1;
        end else begin
            y0 = int'(yi);
            y1 = y0 + 1;
        end
        sum = (FULL_WGT - wx) * (FULL_WGT - wy) * src_img[y0 * ROW_PITCH + x0]
            + wx * (FULL_WGT - wy) * src_img[y0 * ROW_PITCH + x1]
            + (FULL_WGT - wx) * wy * src_img[y1 * ROW_PITCH + x0]
            + wx * wy * src_img[y1 * ROW_PITCH + x1]
            + SUM_ROUND;
        return 8'(sum >> 16);
    endfunction

    always @(posedge i_clk) begin : watch
        logic [7:0] want;
        if (!i_rst_n) begin
            width_reg  = MAX_SRC_WIDTH;
            height_reg = MAX_SRC_HEIGHT;
            xstep_reg  = STEP_W'(1 << FRAC_BITS);
            ystep_reg  = STEP_W'(1 << FRAC_BITS);
            xofs_reg   = '0;
            yofs_reg   = '0;
            expected_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SRC_WIDTH:  width_reg  = i_cfg_data[SIZE_W-1:0];
                    REG_SRC_HEIGHT: height_reg = i_cfg_data[SIZE_W-1:0];
                    REG_X_STEP:     xstep_reg  = i_cfg_data[STEP_W-1:0];
                    REG_Y_STEP:     ystep_reg  = i_cfg_data[STEP_W-1:0];
                    REG_X_OFFSET:   xofs_reg   = i_cfg_data[OFS_W-1:0];
                    REG_Y_OFFSET:   yofs_reg   = i_cfg_data[OFS_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == CMD_LOAD)
                    src_img[i_s_tdata[15:0]] = i_s_tdata[23:16];
                else
                    expected_pixels.push_back(interp_pixel(i_s_tdata[33:24], i_s_tdata[43:34]));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_pixels.size() == 0) begin
                    $error("out_pixel: expected none, actual %0d", i_m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (want !== i_m_tdata) begin
                        $error("out_pixel mismatch: expected %0d, actual %0d", want, i_m_tdata);
                        mismatch_count++;
                    end
                end
            end
        end
        o_pending <= expected_pixels.size();
    end

endmodule

// ===== sim/tb_bilinear_image_scaler.sv =====
// testbench top for the bilinear image scaler: stimulus, flow control and verdict
module tb_bilinear_image_scaler;
    import bis_pkg::*;

    localparam int ITEM_GOAL     = 1600;  // stop starting new phases past this
    localparam int CALM_FROM     = 1400;  // no idling on either side from here on
    localparam int QUIET_LIMIT   = 2000;  // cycles without any transaction before giving up
    localparam int SETTLE_CYCLES = 16;    // idle margin after the outputs drain

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic [TDATA_W-1:0]    s_axis_tdata  = '0;
    logic                  s_axis_tuser  = CMD_LOAD;
    logic                  m_axis_tready = 1'b1;
    logic                  s_axis_tready;
    logic                  m_axis_tvalid;
    logic [7:0]            m_axis_tdata;
    int                    fail_count;
    int                    pending_pixels;

    // stimulus bookkeeping: which store entries hold data, active image size
    bit                    loaded [0:65535];
    int                    cur_w;
    int                    cur_h;
    int                    items_sent   = 0;
    bit                    calm         = 1'b0;
    int                    gap_odds     = 0;
    int                    stall_odds   = 4;
    int                    stall_left   = 0;
    int                    quiet_cycles = 0;

    bilinear_image_scaler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    bis_pixel_checker pixel_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_pixels)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // output side back-pressure: random stall bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            stall_left    <= $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog: any transaction on either stream restarts the count
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // one input transaction, with an occasional idle burst in front of it
    task automatic send_item(input logic cmd, input logic [TDATA_W-1:0] data);
        @(negedge i_clk);
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = data;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        if (items_sent >= CALM_FROM)
            calm = 1'b1;
    endtask

    // load transaction; destination fields carry noise the block must ignore
    task automatic send_load(input int col, input int row, input int val);
        logic [19:0] junk;
        junk = 20'($urandom());
        send_item(CMD_LOAD, {4'b0, junk, 8'(val), 8'(row), 8'(col)});
        loaded[row * int'(MAX_SRC_WIDTH) + col] = 1'b1;
    endtask

    // query transaction; source fields carry noise
    task automatic send_query(input int dc, input int dr);
        logic [23:0] junk;
        junk = 24'($urandom());
        send_item(CMD_QUERY, {4'b0, 10'(dr), 10'(dc), junk});
    endtask

    // hold the input side until every predicted pixel has come out
    task automatic settle_outputs();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_pixels != 0) @(negedge i_clk);
    endtask

    // full idle before touching config: drained outputs plus SETTLE_CYCLES idle cycles
    task automatic quiesce();
        settle_outputs();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    function automatic int clamp_dim(int v, int lim);
        if (v == 0) return 1;
        return (v > lim) ? lim : v;
    endfunction

    function automatic int pick_value();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // mostly a step that spreads the destination range over the image
    function automatic logic [STEP_W-1:0] pick_step(int span, int dst_span);
        int base;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return STEP_W'(1);
            2:       return '1;
            3:       return STEP_W'($urandom());
            default: begin
                base = ((span << FRAC_BITS) / dst_span) + $urandom_range(0, 2000) - 1000;
                if (base < 0) base = 0;
                if (base > 24'hFFFFFF) base = 24'hFFFFFF;
                return STEP_W'(base);
            end
        endcase
    endfunction

    // mostly within two pixels of the origin, sometimes the register extremes
    function automatic logic [OFS_W-1:0] pick_offset();
        int v;
        case ($urandom_range(0, 7))
            0:       return 25'h1000000;
            1:       return 25'h0FFFFFF;
            2:       return OFS_W'($urandom());
            default: begin
                v = $urandom_range(0, 4 << FRAC_BITS) - (2 << FRAC_BITS);
                return OFS_W'(v);
            end
        endcase
    endfunction

    function automatic int pick_index(int dst_span);
        case ($urandom_range(0, 15))
            0:       return 1023;
            1:       return $urandom_range(0, 1023);
            2:       return 0;
            default: return $urandom_range(0, dst_span);
        endcase
    endfunction

    function automatic int pick_odds();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 3;
            default: return 10;
        endcase
    endfunction

    // make sure every pixel a query can touch has been written
    task automatic fill_image(input int w, input int h, input bit refresh);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                if (!loaded[r * int'(MAX_SRC_WIDTH) + c] || (refresh && $urandom_range(0, 3) == 0))
                    send_load(c, r, pick_value());
    endtask

    // one configuration setting: program, fill the image, then a burst of queries
    task automatic run_phase();
        int wv, hv, dst_w, dst_h, nq;
        case ($urandom_range(0, 11))
            0: begin
                // full width, sizes above the store clamp
                wv = $urandom_range(0, 1) ? 256 : $urandom_range(257, 511);
                hv = $urandom_range(0, 2);
            end
            1: begin
                wv = $urandom_range(0, 2);
                hv = $urandom_range(0, 1) ? 256 : $urandom_range(257, 511);
            end
            2: begin
                wv = $urandom_range(0, 1);
                hv = $urandom_range(0, 1);
            end
            default: begin
                wv = $urandom_range(0, 16);
                hv = $urandom_range(1, 16);
            end
        endcase
        cur_w = clamp_dim(wv, int'(MAX_SRC_WIDTH));
        cur_h = clamp_dim(hv, int'(MAX_SRC_HEIGHT));
        dst_w = $urandom_range(1, 48);
        dst_h = $urandom_range(1, 48);
        write_reg(REG_SRC_WIDTH, CFG_DATA_W'(wv));
        write_reg(REG_SRC_HEIGHT, CFG_DATA_W'(hv));
        write_reg(REG_X_STEP, CFG_DATA_W'(pick_step(cur_w, dst_w)));
        write_reg(REG_Y_STEP, CFG_DATA_W'(pick_step(cur_h, dst_h)));
        write_reg(REG_X_OFFSET, pick_offset());
        write_reg(REG_Y_OFFSET, pick_offset());
        gap_odds   = pick_odds();
        stall_odds = pick_odds();
        fill_image(cur_w, cur_h, cur_w * cur_h <= 64);
        nq = $urandom_range(20, 60);
        repeat (nq) begin
            // stray loads anywhere in the store, also outside the active image
            if ($urandom_range(0, 9) == 0)
                send_load($urandom_range(0, 255), $urandom_range(0, 255), pick_value());
            send_query(pick_index(dst_w), pick_index(dst_h));
            if ($urandom_range(0, 79) == 0)
                settle_outputs();
        end
        quiesce();
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // 2x2 image, half-pixel steps starting half a pixel before the origin
        write_reg(REG_SRC_WIDTH, 25'd2);
        write_reg(REG_SRC_HEIGHT, 25'd2);
        write_reg(REG_X_STEP, 25'h20000);
        write_reg(REG_Y_STEP, 25'h20000);
        write_reg(REG_X_OFFSET, 25'h1FE0000);
        write_reg(REG_Y_OFFSET, 25'h1FE0000);
        send_load(0, 0, 0);
        send_load(1, 0, 255);
        send_load(0, 1, 255);
        send_load(1, 1, 128);
        // corners of the store, outside the active image
        send_load(255, 255, 8'hAA);
        send_load(255, 0, 8'h55);
        send_query(0, 0);         // negative position, top-left clamp
        send_query(1, 1);         // interior, exact pixel
        send_query(2, 2);         // between pixels
        send_query(3, 3);         // right and bottom edge
        send_query(1023, 0);
        send_query(0, 1023);
        send_query(1023, 1023);   // far past the image
        quiesce();

        // zero size acts as one pixel, zero steps pin every query to the offset
        write_reg(REG_SRC_WIDTH, 25'd0);
        write_reg(REG_SRC_HEIGHT, 25'd0);
        write_reg(REG_X_STEP, 25'd0);
        write_reg(REG_Y_STEP, 25'd0);
        write_reg(REG_X_OFFSET, 25'h0FFFFFF);
        write_reg(REG_Y_OFFSET, 25'h1000000);
        send_query(0, 0);
        send_query(1023, 1023);
        quiesce();

        while (items_sent < ITEM_GOAL)
            run_phase();

        quiesce();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bis_pkg.sv
sv/bis_mac.sv
sv/bis_split.sv
sv/bilinear_image_scaler.sv
sim/bis_pixel_checker.sv
sim/tb_bilinear_image_scaler.sv
